// ===== rtl/sha512_pkg.sv =====
package sha512_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic init_hash;    // reload chaining words, clear count
        logic store_word;   // write wr_word at position, advance
        logic add_count;    // add 8 (or last word's valid bytes) to byte count
        logic zero_fill;    // write zero at position, advance
        logic len_fill;     // write length words into 14 and 15
        logic round_start;  // load working vars from chaining words
        logic round_step;   // one round
        logic round_end;    // fold working vars into chaining words
        logic shift_out;    // rotate chaining words for output
        logic [1:0] word_sel; // 0 data, 1 marker word, 2 masked last word
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] position;
        logic [6:0] round;
    } dp_status_t;

    localparam logic [1:0] SEL_DATA   = 2'd0;
    localparam logic [1:0] SEL_MARKER = 2'd1;
    localparam logic [1:0] SEL_LAST   = 2'd2;

    localparam int unsigned NUM_ROUNDS = 80;

    function automatic logic [63:0] init_word(input logic [2:0] i);
        case (i)
            3'd0: init_word = 64'h6a09e667f3bcc908;
            3'd1: init_word = 64'hbb67ae8584caa73b;
            3'd2: init_word = 64'h3c6ef372fe94f82b;
            3'd3: init_word = 64'ha54ff53a5f1d36f1;
            3'd4: init_word = 64'h510e527fade682d1;
            3'd5: init_word = 64'h9b05688c2b3e6c1f;
            3'd6: init_word = 64'h1f83d9abfb41bd6b;
            default: init_word = 64'h5be0cd19137e2179;
        endcase
    endfunction

    localparam logic [63:0] ROUND_K [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

// ===== rtl/sha512_datapath.sv =====
module sha512_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha512_pkg::dp_cmd_t   cmd,
    input  sha512_pkg::in_item_t  item,
    output sha512_pkg::dp_status_t status,
    output logic [63:0]           head_word
);

    logic [63:0] hash_reg [0:7];
    logic [63:0] w_reg [0:15];
    logic [63:0] v_reg [0:7];
    logic [3:0]  pos_reg;
    logic [6:0]  round_reg;
    logic [127:0] count_reg;

    logic [63:0] wr_word;
    logic [3:0]  nb;
    logic [63:0] keep_mask;
    logic [63:0] marker;
    logic [127:0] bits;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    always_comb
    begin
        nb = (item.valid_bytes > 4'd8) ? 4'd8 : item.valid_bytes;
        keep_mask = ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
        if (nb == 4'd0)
            keep_mask = '0;
        marker = (nb == 4'd8) ? 64'd0 : (64'h8000_0000_0000_0000 >> {nb[2:0], 3'b000});
        case (cmd.word_sel)
            sha512_pkg::SEL_DATA:   wr_word = item.data_word;
            sha512_pkg::SEL_MARKER: wr_word = 64'h8000_0000_0000_0000;
            sha512_pkg::SEL_LAST:   wr_word = (item.data_word & keep_mask) | marker;
            default:                wr_word = item.data_word;
        endcase
    end

    // schedule word and round arithmetic
    logic [63:0] x2, x15, s0, s1, w_new, wt;
    logic [63:0] e, a, big0, big1, ch, maj, t1, t2;
    always_comb
    begin
        x2 = w_reg[14];
        x15 = w_reg[1];
        s1 = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
        s0 = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        wt = w_reg[0];
        e = v_reg[4];
        a = v_reg[0];
        big1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
        ch = (e & v_reg[5]) ^ (~e & v_reg[6]);
        big0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
        maj = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + big1 + ch + sha512_pkg::ROUND_K[round_reg] + wt;
        t2 = big0 + maj;
        bits = {count_reg[124:0], 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            round_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha512_pkg::init_word(3'(i));
        end
        else
        begin
            if (cmd.round_start)
                round_reg <= '0;
            else if (cmd.round_step)
                round_reg <= round_reg + 7'd1;
            if (cmd.init_hash)
            begin
                count_reg <= '0;
                pos_reg <= '0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= sha512_pkg::init_word(3'(i));
            end
            else
            begin
                if (cmd.add_count)
                    count_reg <= count_reg + (item.last_word ? 128'(nb) : 128'd8);
                if (cmd.len_fill)
                    pos_reg <= '0;
                else if (cmd.store_word || cmd.zero_fill)
                    pos_reg <= pos_reg + 4'd1;
                if (cmd.round_end)
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                else if (cmd.shift_out)
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[(i + 1) % 8];
            end
        end
    end

    // block buffer doubles as the rolling schedule window
    always_ff @(posedge clk)
    begin
        if (cmd.store_word)
            w_reg[pos_reg] <= wr_word;
        if (cmd.zero_fill)
            w_reg[pos_reg] <= '0;
        if (cmd.len_fill)
        begin
            w_reg[14] <= bits[127:64];
            w_reg[15] <= bits[63:0];
        end
        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.round_start)
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_reg[i];
    end

    assign status.position = pos_reg;
    assign status.round = round_reg;
    assign head_word = hash_reg[0];

endmodule

// ===== rtl/sha512_ctrl.sv =====
module sha512_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  sha512_pkg::in_item_t   item,
    output logic                   in_stall,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [2:0]             out_index,
    input  sha512_pkg::dp_status_t status,
    output sha512_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MARK, S_PAD, S_START, S_ROUND, S_FOLD, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;      // compressing the final block
    logic [2:0] idx_reg, idx_next;

    // a message end is in progress; blocks that follow are padding
    logic pending_pad, pend_reg, pend_next;
    logic mark_due_reg, mark_due_next;

    logic take;
    logic [3:0] nb;

    assign in_stall = (state_reg != S_IDLE);
    assign take = in_valid && (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;
    assign nb = (item.valid_bytes > 4'd8) ? 4'd8 : item.valid_bytes;
    assign pending_pad = pend_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        fin_next = fin_reg;
        idx_next = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.store_word = 1'b1;
                    cmd.add_count = 1'b1;
                    if (!item.last_word)
                    begin
                        cmd.word_sel = sha512_pkg::SEL_DATA;
                        if (status.position == 4'd15)
                        begin
                            fin_next = 1'b0;
                            state_next = S_START;
                        end
                    end
                    else if (nb == 4'd8)
                    begin
                        cmd.word_sel = sha512_pkg::SEL_DATA;
                        fin_next = 1'b0;
                        state_next = (status.position == 4'd15) ? S_START : S_MARK;
                    end
                    else
                    begin
                        cmd.word_sel = sha512_pkg::SEL_LAST;
                        fin_next = 1'b1;
                        state_next = S_PAD;
                        if (status.position >= 4'd14)
                        begin
                            fin_next = 1'b0;
                            state_next = (status.position == 4'd15) ? S_START : S_PAD;
                        end
                    end
                end
            end
            S_MARK:
            begin
                // marker word after a full last word
                cmd.store_word = 1'b1;
                cmd.word_sel = sha512_pkg::SEL_MARKER;
                fin_next = (status.position < 4'd14);
                state_next = (status.position == 4'd15) ? S_START : S_PAD;
            end
            S_PAD:
            begin
                if (fin_reg && status.position == 4'd14)
                begin
                    cmd.len_fill = 1'b1;
                    state_next = S_START;
                end
                else
                begin
                    cmd.zero_fill = 1'b1;
                    if (status.position == 4'd15)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.round_start = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (status.round == 7'(sha512_pkg::NUM_ROUNDS - 1))
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.round_end = 1'b1;
                idx_next = '0;
                if (fin_reg)
                    state_next = S_OUT;
                else if (mark_due_reg)
                    // full last word filled the block: marker goes into the next one
                    state_next = S_MARK;
                else if (status.position == 4'd0 && !pending_pad)
                    state_next = S_IDLE;
                else
                begin
                    fin_next = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.init_hash = 1'b1;
                        fin_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        mark_due_next = mark_due_reg;
        if (take && item.last_word)
        begin
            pend_next = 1'b1;
            mark_due_next = (nb == 4'd8) && (status.position == 4'd15);
        end
        if (state_reg == S_OUT && !out_stall && idx_reg == 3'd7)
            pend_next = 1'b0;
        if (state_reg == S_MARK)
            mark_due_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg <= 1'b0;
            idx_reg <= '0;
            pend_reg <= 1'b0;
            mark_due_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
            idx_reg <= idx_next;
            pend_reg <= pend_next;
            mark_due_reg <= mark_due_next;
        end
    end

endmodule

// ===== rtl/sha512_hash_engine_top.sv =====
// SHA-512 engine. Message words are taken one per transaction while the engine is
// idle; every sixteenth word starts a compression (load, 80 rounds at one round
// per cycle, fold), during which input is stalled. The last word adds padding
// words and one or two compressions, then the digest leaves as eight
// transactions, word 0 first, after which the engine is ready for a new message.
// The single round unit sets the rate: input is stalled for each block's
// compression, so no new word is taken until that block has been folded.
module sha512_hash_engine_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha512_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha512_pkg::out_item_t out_data
);

    sha512_pkg::dp_cmd_t    cmd;
    sha512_pkg::dp_status_t status;
    logic [63:0] head_word;
    logic [2:0]  out_index;

    sha512_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item      (in_data),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_index (out_index),
        .status    (status),
        .cmd       (cmd)
    );

    sha512_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (in_data),
        .status    (status),
        .head_word (head_word)
    );

    assign out_data.digest_word = head_word;
    assign out_data.word_index  = out_index;
    assign out_data.digest_last = (out_index == 3'd7);

endmodule
